[src/u2c_pkg.sv]
// ----------------------------------------------------------------------------
// u2c_pkg: shared types and constants for the UTF-8 to CP1252 transcoder
// Holds the CP1252 extras table, the register indexes and the map result type.
// ----------------------------------------------------------------------------
package u2c_pkg;

    localparam int CP_WIDTH    = 21;
    localparam int COUNT_WIDTH = 12;

    // Configuration register indexes
    typedef enum logic {
        CFG_MAX_OUTPUT_BYTES = 1'b0,
        CFG_SUBSTITUTE_MODE  = 1'b1
    } cfg_index_t;

    localparam logic [COUNT_WIDTH-1:0] MAX_OUT_RESET = 12'd255;

    localparam logic [7:0] BYTE_QMARK  = 8'h3F;
    localparam logic [7:0] BYTE_NBSP   = 8'hA0;
    localparam logic [7:0] BYTE_SHY    = 8'hAD;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_MATCH  = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_MATCH = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_MATCH = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_MATCH = 8'hF0;

    // Code points of the CP1252 bytes 0x80-0x9F; zero marks an undefined byte
    localparam logic [15:0] HIGH_EXTRAS [32] = '{
        16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
        16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
    };

    typedef struct packed {
        logic       hit;    // code point has a CP1252 byte
        logic       glyph;  // that byte is a printable flap glyph
        logic [7:0] code;
    } map_res_t;

endpackage

[src/u2c_map.sv]
// ----------------------------------------------------------------------------
// u2c_map: code point to CP1252 byte lookup
// Direct ranges pass through; the 0x80-0x9F extras are matched in parallel.
// ----------------------------------------------------------------------------
module u2c_map (
    input  logic [u2c_pkg::CP_WIDTH-1:0] cp,
    output u2c_pkg::map_res_t            res
);
    import u2c_pkg::*;

    always_comb begin
        res = '0;
        if ((cp >= 21'h20 && cp <= 21'h7E) || (cp >= 21'hA0 && cp <= 21'hFF)) begin
            res.hit  = 1'b1;
            res.code = cp[7:0];
        end else begin
            for (int i = 0; i < 32; i++) begin
                if (HIGH_EXTRAS[i] != 16'h0000 && {5'b0, HIGH_EXTRAS[i]} == cp) begin
                    res.hit  = 1'b1;
                    res.code = 8'h80 | 8'(i);
                end
            end
        end
        // drop NBSP and soft hyphen as flap glyphs
        res.glyph = res.hit && res.code != BYTE_NBSP && res.code != BYTE_SHY;
    end

endmodule

[src/utf8_to_cp1252_transcoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_cp1252_transcoder: streaming UTF-8 to CP1252 byte transcoder
// Decodes one UTF-8 byte per beat and emits CP1252 bytes plus an end summary.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  input   | s_valid / s_ready   | s_data_byte (zero ends the string)
//  result  | m_valid / m_ready   | m_out_byte, m_end_flag, m_byte_count, m_all_mapped
//  config  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One beat per cycle sustained. A byte is held in the input register, where
//  the decode, map and limit logic run, then lands in the result register.
//  A stall on m_ready holds the result register and backs up into the input
//  register; s_ready drops only when both are full.
//  aresetn (synchronous) clears the decoder state, empties both registers and
//  restores the registers to max_output_bytes = 255, substitute_mode = 0.
//  cfg_ready is always high.
//
module utf8_to_cp1252_transcoder (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_data_byte,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_out_byte,
    output logic                            m_end_flag,
    output logic [u2c_pkg::COUNT_WIDTH-1:0] m_byte_count,
    output logic                            m_all_mapped,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  u2c_pkg::cfg_index_t             cfg_index,
    input  logic [u2c_pkg::COUNT_WIDTH-1:0] cfg_data
);
    import u2c_pkg::*;

    // Configuration registers
    logic [COUNT_WIDTH-1:0] max_out_reg;
    logic                   sub_mode_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Per-string decoder state
    logic [1:0]             cont_left_reg,  cont_left_next;
    logic [CP_WIDTH-1:0]    acc_reg,        acc_next;
    logic [COUNT_WIDTH-1:0] count_reg,      count_next;
    logic                   flag_reg,       flag_next;
    logic                   stopped_reg,    stopped_next;

    // Result register
    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    logic                   out_end_reg;
    logic [COUNT_WIDTH-1:0] out_count_reg;
    logic                   out_mapped_reg;

    // Step logic
    logic                   advance;
    logic                   produce;
    logic                   emit;
    logic [7:0]             emit_byte;
    logic                   drop_flag;
    logic                   cut_off;
    logic                   end_beat;
    logic                   end_mapped;
    logic                   finish;
    logic [CP_WIDTH-1:0]    finish_cp;
    logic [CP_WIDTH-1:0]    acc_shift;
    logic                   is_cont;
    logic                   at_limit;
    map_res_t               map_res;

    // The input register moves on whenever the result register is free or drains
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign is_cont   = (in_byte_reg & CONT_MASK) == CONT_MATCH;
    assign at_limit  = count_reg >= max_out_reg;
    assign acc_shift = {acc_reg[CP_WIDTH-7:0], in_byte_reg[5:0]};

    u2c_map u_map (
        .cp  (finish_cp),
        .res (map_res)
    );

    // Decode: work out the next state and whether this byte finishes a character
    always_comb begin
        cont_left_next = cont_left_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        flag_next      = flag_reg;
        stopped_next   = stopped_reg;
        end_beat       = 1'b0;
        end_mapped     = 1'b0;
        finish         = 1'b0;
        finish_cp      = {{(CP_WIDTH-8){1'b0}}, in_byte_reg};

        priority if (in_byte_reg == 8'h00) begin
            // end of string: report, then return to the clean state
            end_beat       = 1'b1;
            end_mapped     = sub_mode_reg || (flag_reg && cont_left_reg == 2'd0);
            cont_left_next = 2'd0;
            acc_next       = '0;
            count_next     = '0;
            flag_next      = 1'b1;
            stopped_next   = 1'b0;
        end else if (stopped_reg) begin
            // ignore everything up to the terminator
        end else if (cont_left_reg != 2'd0 && is_cont) begin
            acc_next       = acc_shift;
            cont_left_next = cont_left_reg - 2'd1;
            finish_cp      = acc_shift;
            finish         = cont_left_reg == 2'd1;
        end else begin
            // drop a broken sequence, then treat the byte as a lead byte
            if (cont_left_reg != 2'd0) begin
                cont_left_next = 2'd0;
                acc_next       = '0;
                flag_next      = 1'b0;
            end
            priority if (sub_mode_reg && at_limit) begin
                stopped_next = 1'b1;
            end else if (!in_byte_reg[7]) begin
                finish = 1'b1;
            end else if ((in_byte_reg & LEAD2_MASK) == LEAD2_MATCH) begin
                acc_next       = {{(CP_WIDTH-5){1'b0}}, in_byte_reg[4:0]};
                cont_left_next = 2'd1;
            end else if ((in_byte_reg & LEAD3_MASK) == LEAD3_MATCH) begin
                acc_next       = {{(CP_WIDTH-4){1'b0}}, in_byte_reg[3:0]};
                cont_left_next = 2'd2;
            end else if ((in_byte_reg & LEAD4_MASK) == LEAD4_MATCH) begin
                acc_next       = {{(CP_WIDTH-3){1'b0}}, in_byte_reg[2:0]};
                cont_left_next = 2'd3;
            end else begin
                flag_next = 1'b0;
            end
        end
    end

    // Finish a character: substitute, filter or cut off at the limit.
    // Filter mode clears the flag on a dropped glyph or a cut-off character,
    // and a cut-off character also stops output until the terminator.
    always_comb begin
        emit      = 1'b0;
        emit_byte = map_res.code;
        drop_flag = 1'b0;
        cut_off   = 1'b0;
        if (finish) begin
            priority if (sub_mode_reg) begin
                emit      = 1'b1;
                emit_byte = map_res.hit ? map_res.code : BYTE_QMARK;
            end else if (!map_res.glyph) begin
                emit      = 1'b0;
                drop_flag = 1'b1;
            end else if (!at_limit) begin
                emit = 1'b1;
            end else begin
                emit      = 1'b0;
                drop_flag = 1'b1;
                cut_off   = 1'b1;
            end
        end
    end

    assign produce = emit || end_beat;

    // Input register and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            max_out_reg  <= MAX_OUT_RESET;
            sub_mode_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_MAX_OUTPUT_BYTES: max_out_reg  <= cfg_data;
                    CFG_SUBSTITUTE_MODE:  sub_mode_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // Decoder state: advance only when the byte leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cont_left_reg <= 2'd0;
            acc_reg       <= '0;
            count_reg     <= '0;
            flag_reg      <= 1'b1;
            stopped_reg   <= 1'b0;
        end else if (advance) begin
            cont_left_reg <= cont_left_next;
            acc_reg       <= acc_next;
            flag_reg      <= flag_next && !drop_flag;
            stopped_reg   <= stopped_next || cut_off;
            if (emit) begin
                count_reg <= count_reg + 12'd1;
            end else begin
                count_reg <= count_next;
            end
        end
    end

    // Result register: load on a producing step, empty when drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= produce;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && produce) begin
            out_byte_reg   <= end_beat ? 8'h00 : emit_byte;
            out_end_reg    <= end_beat;
            out_count_reg  <= end_beat ? count_reg : '0;
            out_mapped_reg <= end_beat && end_mapped;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_end_flag   = out_end_reg;
    assign m_byte_count = out_count_reg;
    assign m_all_mapped = out_mapped_reg;

endmodule
